### rtl/core/ole_pkg.sv
// Package for the ordered list engine: command and result item types,
// operation codes and status codes. Depends on nothing.
package ole_pkg;

  localparam int DATA_W = 32;

  // Operation codes carried in the mode field of a command item.
  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_INSERT  = 3'd1;
  localparam logic [2:0] MODE_DEL_POS = 3'd2;
  localparam logic [2:0] MODE_DEL_VAL = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;

  // Status codes reported in a result item.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [6:0]               position;
  } in_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [5:0]               removed_position;
    logic [6:0]               entry_count;
  } out_t;

endpackage

### rtl/core/ole_mem.sv
// Entry store of the ordered list engine: one write port and one read port,
// read data registered. Uses ole_pkg for the data width.
module ole_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ole_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ole_pkg::DATA_W-1:0] rdata
);

  logic [ole_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/ole_ctrl.sv
// Sequencer of the ordered list engine: decodes command items, streams the
// entry store for shifts and searches, and builds the result item.
// Uses ole_pkg; drives the ports of ole_mem.
module ole_ctrl #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ole_pkg::in_t               cmd,
  output logic                       done,
  output ole_pkg::out_t              result,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ole_pkg::DATA_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ole_pkg::DATA_W-1:0] mem_rdata
);

  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SCAN = 4'b0100,
    S_SHDN = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic [CW-1:0]              rem, rem_next;
  logic [AW-1:0]              ridx, ridx_next;
  logic [AW-1:0]              ra, ra_next;
  logic                       pv, pv_next;
  logic [AW-1:0]              op_pos, op_pos_next;
  logic [ole_pkg::DATA_W-1:0] op_val, op_val_next;
  logic                       is_delpos, is_delpos_next;
  logic                       done_next;
  ole_pkg::out_t              result_next;

  logic [PW-1:0] pos_w, cnt_w, cnt_next_w, ra_w;
  logic [CW-1:0] cnt_m1;
  logic          full;

  assign pos_w      = PW'(cmd.position);
  assign cnt_w      = PW'(cnt);
  assign cnt_next_w = PW'(cnt_next);
  assign ra_w       = PW'(ra);
  assign cnt_m1     = cnt - 1'b1;
  assign full       = (cnt_w >= PW'(CAPACITY));
  assign busy       = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    rem_next       = rem;
    ridx_next      = ridx;
    ra_next        = ra;
    pv_next        = 1'b0;
    op_pos_next    = op_pos;
    op_val_next    = op_val;
    is_delpos_next = is_delpos;
    done_next      = 1'b0;
    result_next    = result;
    mem_we         = 1'b0;
    mem_waddr      = op_pos;
    mem_wdata      = op_val;
    mem_re         = 1'b0;
    mem_raddr      = ridx;

    // In the streaming states a read goes out each cycle while entries remain.
    if (state != S_IDLE && rem != '0) begin
      mem_re   = 1'b1;
      rem_next = rem - 1'b1;
      pv_next  = 1'b1;
      ra_next  = ridx;
      if (state == S_INS) begin
        ridx_next = ridx - 1'b1;
      end else begin
        ridx_next = ridx + 1'b1;
      end
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          op_val_next = cmd.value;
          result_next = '0;
          case (cmd.mode)
            ole_pkg::MODE_APPEND: begin
              if (full) begin
                result_next.status = ole_pkg::ST_FULL;
                done_next = 1'b1;
              end else begin
                op_pos_next = cnt[AW-1:0];
                rem_next    = '0;
                state_next  = S_INS;
              end
            end
            ole_pkg::MODE_INSERT: begin
              if (full) begin
                result_next.status = ole_pkg::ST_FULL;
                done_next = 1'b1;
              end else if (cmd.position != '0 && pos_w >= cnt_w) begin
                result_next.status = ole_pkg::ST_RANGE;
                done_next = 1'b1;
              end else begin
                op_pos_next = pos_w[AW-1:0];
                rem_next    = CW'(cnt_w - pos_w);
                ridx_next   = cnt_m1[AW-1:0];
                state_next  = S_INS;
              end
            end
            ole_pkg::MODE_DEL_POS: begin
              if (cnt == '0) begin
                result_next.status = ole_pkg::ST_EMPTY;
                done_next = 1'b1;
              end else if (pos_w >= cnt_w) begin
                result_next.status = ole_pkg::ST_RANGE;
                done_next = 1'b1;
              end else begin
                ridx_next      = pos_w[AW-1:0];
                rem_next       = CW'(cnt_w - pos_w);
                is_delpos_next = 1'b1;
                state_next     = S_SCAN;
              end
            end
            ole_pkg::MODE_DEL_VAL: begin
              if (cnt == '0) begin
                result_next.status = ole_pkg::ST_EMPTY;
                done_next = 1'b1;
              end else begin
                ridx_next      = '0;
                rem_next       = cnt;
                is_delpos_next = 1'b0;
                state_next     = S_SCAN;
              end
            end
            ole_pkg::MODE_CLEAR: begin
              cnt_next  = '0;
              done_next = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // Entries move up by one, from the tail down to the insert position.
        if (pv) begin
          mem_we    = 1'b1;
          mem_waddr = ra + 1'b1;
          mem_wdata = mem_rdata;
        end else if (rem == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = op_pos;
          mem_wdata  = op_val;
          cnt_next   = cnt + 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SCAN: begin
        // The read of the next entry is already out when a match shows up,
        // so the shift phase picks up the stream without a gap.
        if (pv) begin
          if (is_delpos || mem_rdata == op_val) begin
            result_next.removed_value    = mem_rdata;
            result_next.removed_position = ra_w[5:0];
            state_next = S_SHDN;
          end else if (ra == cnt_m1[AW-1:0]) begin
            result_next.status = ole_pkg::ST_NOTFOUND;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_SHDN: begin
        // Entries behind the removed one move down by one.
        if (pv) begin
          mem_we    = 1'b1;
          mem_waddr = ra - 1'b1;
          mem_wdata = mem_rdata;
        end else if (rem == '0) begin
          cnt_next   = cnt_m1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done_next) begin
      result_next.entry_count = cnt_next_w[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rem   <= '0;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      rem   <= rem_next;
      pv    <= pv_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ridx      <= ridx_next;
    ra        <= ra_next;
    op_pos    <= op_pos_next;
    op_val    <= op_val_next;
    is_delpos <= is_delpos_next;
    result    <= result_next;
  end

endmodule

### rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: the sequencer and the entry store.
// Uses ole_pkg, ole_mem and ole_ctrl.
//
// The block keeps an ordered list of signed 32-bit values, up to CAPACITY
// entries, in a single memory at positions 0 to count-1. A command item is
// taken at a rising edge where start is high and busy is low; it appends,
// inserts at a position, deletes at a position, deletes the first entry
// equal to a value, or clears the list. Every item yields one result item,
// shown on result for exactly one cycle while done is high. The receiver
// cannot hold a result off, so it must take it in that cycle.
// Clear, rejected items and unused modes finish straight from idle. An
// insert reads from the tail down to its position and writes each entry
// one place up, then writes the new value at the position; an append does
// only that last write. A delete reads from its start position (zero for a
// search) to the tail and moves the entries behind the removed one down.
// One entry moves per cycle through the memory's single read port and
// single write port. Items are handled one at a time: busy stays high
// until the result is on its way, and the next item can be taken in the
// cycle in which done is high.
// Reset clears the entry count; the memory itself is not cleared, since only
// entries below the count are ever read.
module ordered_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ole_pkg::in_t  cmd,
  output logic          done,
  output ole_pkg::out_t result
);

  localparam int AW = $clog2(CAPACITY);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ole_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [ole_pkg::DATA_W-1:0] mem_rdata;

  // Sequencer: decodes the command and streams the store one entry a cycle.
  ole_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Entry store with registered read data. Reads always run ahead of
  // writes in the direction of a shift, so the two ports never collide.
  ole_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
